// ===== sv/kwl_pkg.sv =====
`timescale 1ns / 1ps

package kwl_pkg;

  // Defaults for the top-level parameters.
  localparam int KWL_KEYWORD_MAX_LEN = 8;
  localparam int KWL_POSITION_BITS   = 16;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] RT_BYTE  = 2'd0;
  localparam logic [1:0] RT_TOKEN = 2'd1;
  localparam logic [1:0] RT_END   = 2'd2;
  localparam logic [1:0] RT_ERROR = 2'd3;

  // Token codes above the single-character range.
  localparam int          KW_BASE        = 256;
  localparam int          KW_COUNT       = 35;
  localparam int          KW_RETURN_IDX  = 22;
  localparam int          KW_CMP_LEN     = 7;
  localparam logic [8:0]  TK_GTE         = 9'd291;
  localparam logic [8:0]  TK_LTE         = 9'd292;
  localparam logic [8:0]  TK_NEQ         = 9'd293;
  localparam logic [8:0]  TK_ASSIGN_MOD  = 9'd294;
  localparam logic [8:0]  TK_ASSIGN_AND  = 9'd295;
  localparam logic [8:0]  TK_ASSIGN_MUL  = 9'd296;
  localparam logic [8:0]  TK_ASSIGN_SUB  = 9'd297;
  localparam logic [8:0]  TK_ASSIGN_ADD  = 9'd298;
  localparam logic [8:0]  TK_ASSIGN_DIV  = 9'd299;
  localparam logic [8:0]  TK_ASSIGN_OR   = 9'd300;
  localparam logic [8:0]  TK_RSHASSIGN   = 9'd301;
  localparam logic [8:0]  TK_LSHASSIGN   = 9'd302;
  localparam logic [8:0]  TK_MODASSIGN   = 9'd303;
  localparam logic [8:0]  TK_CRETURN     = 9'd304;
  localparam logic [8:0]  TK_STRING      = 9'd305;
  localparam logic [8:0]  TK_CONSTANT    = 9'd306;
  localparam logic [8:0]  TK_HEX         = 9'd307;
  localparam logic [8:0]  TK_CHARCONST   = 9'd308;
  localparam logic [8:0]  TK_IDENT       = 9'd309;

  // Keyword text, right-justified, first character highest.
  localparam logic [8*KW_CMP_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "AND", "OR", "ARRAY", "POINTER", "BYTE", "CARD", "INT", "TYPE", "DO",
    "OD", "IF", "ELSEIF", "ELSE", "FI", "FOR", "TO", "STEP", "WHILE", "UNTIL",
    "EXIT", "PROC", "FUNC", "RETURN", "BEGIN", "END", "MODULE", "LSH", "RSH",
    "MOD", "THEN", "CHAR", "DEFINE", "XOR", "LONG", "INCLUDE"
  };
  localparam int KW_LEN [KW_COUNT] = '{
    3, 2, 5, 7, 4, 4, 3, 4, 2,
    2, 2, 6, 4, 2, 3, 2, 4, 5, 5,
    4, 4, 4, 6, 5, 3, 6, 3, 3,
    3, 4, 4, 6, 3, 4, 7
  };

  // Scanner modes.
  typedef enum logic [3:0] {
    M_IDLE,
    M_SLASH,
    M_COMMENT,
    M_CMP,
    M_EQ1,
    M_EQ2,
    M_COLLECT,
    M_STRING,
    M_DEC,
    M_HEX,
    M_QUOTE,
    M_QEND,
    M_WORD
  } mode_t;

  // One character as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eoi;
    logic        cond;
    logic [15:0] line;
    logic [15:0] column;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  rtype;
    logic [8:0]  code;
    logic [7:0]  lexeme;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } result_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
  endfunction

  // Keyword lookup over the first characters of a short word.
  function automatic logic [8:0] kw_code(input logic [KW_CMP_LEN-1:0][7:0] w,
                                         input logic [2:0] n, input logic cond);
    logic [8:0] code;
    logic       hit;
    code = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (int'(n) == KW_LEN[i]);
      for (int k = 0; k < KW_CMP_LEN; k++) begin
        if (k < KW_LEN[i]) begin
          hit = hit && (w[k] == KW_TEXT[i][(KW_LEN[i] - 1 - k) * 8 +: 8]);
        end
      end
      if (hit) begin
        code = (i == KW_RETURN_IDX && cond) ? TK_CRETURN : 9'(KW_BASE + i);
      end
    end
    return code;
  endfunction

endpackage

// ===== sv/keyword_lexer_top.sv =====
`timescale 1ns / 1ps

// Character-at-a-time lexical scanner. Each input transfer carries one source
// byte (or an end marker on tlast) and produces zero to eight result transfers:
// in scan order, with tlast on the final result of that character. A front
// stage counts line and column and writes characters into a four-entry queue;
// the back scanner takes one character per cycle while the output accepts
// results, and holds a character while it produces each additional result or
// re-examines held characters, as after a failed ==xyz guess. The output side
// is registered, so input keeps flowing while a result waits. No clearing pass
// is needed after reset.
module keyword_lexer_top #(
  parameter int KEYWORD_MAX_LEN = kwl_pkg::KWL_KEYWORD_MAX_LEN,
  parameter int POSITION_BITS   = kwl_pkg::KWL_POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] ch
  input  logic        s_axis_tlast,  // end_of_input
  input  logic        s_axis_tuser,  // in_conditional
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // [8:0] token_code, [16:9] lexeme_byte,
                                     // [32:17] line, [48:33] column, rest zero
  output logic        m_axis_tlast,  // last_of_step
  output logic [1:0]  m_axis_tuser   // [1:0] result_type
);
  import kwl_pkg::*;

  logic    q_full, q_push, q_pop, q_head_valid;
  item_t   q_item, q_head;
  result_t res;

  kwl_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_ch    (s_axis_tdata),
    .in_eoi   (s_axis_tlast),
    .in_cond  (s_axis_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  kwl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  kwl_back #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_item  (q_head),
    .pop        (q_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // Pack the result onto the stream.
  assign m_axis_tdata = {7'd0, res.column, res.line, res.lexeme, res.code};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.rtype;

  // End and error results always close the results of their character.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RT_END || m_axis_tuser == RT_ERROR) |-> m_axis_tlast)
    else $error("end or error result without last flag");

  // Lexeme results never carry a token code, token results never carry a byte.
  a_field_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == RT_BYTE ? m_axis_tdata[8:0] == '0
                                               : m_axis_tdata[16:9] == '0))
    else $error("result carries a stray field");

  // The queue never takes a character while it is full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue written while full");

endmodule

// ===== sv/kwl_front.sv =====
`timescale 1ns / 1ps

module kwl_front #(
  parameter int POSITION_BITS = kwl_pkg::KWL_POSITION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_eoi,
  input  logic               in_cond,
  input  logic               q_full,
  output logic               q_push,
  output kwl_pkg::item_t     q_item
);
  import kwl_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] line_cnt, line_cnt_next;
  logic [POSITION_BITS-1:0] col_cnt, col_cnt_next;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Every arriving character is counted once; the end marker is not.
  always_comb begin
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    if (!in_eoi) begin
      if (in_ch == 8'h0A) begin
        if (line_cnt != POS_MAX) line_cnt_next = line_cnt + 1'b1;
        col_cnt_next = '0;
      end else if (col_cnt != POS_MAX) begin
        col_cnt_next = col_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    q_item.ch     = in_ch;
    q_item.eoi    = in_eoi;
    q_item.cond   = in_cond;
    q_item.line   = 16'(line_cnt_next);
    q_item.column = 16'(col_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt <= POSITION_BITS'(1);
      col_cnt  <= '0;
    end else if (q_push) begin
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
    end
  end

endmodule

// ===== sv/kwl_queue.sv =====
`timescale 1ns / 1ps

module kwl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kwl_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output kwl_pkg::item_t head_item
);
  import kwl_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full       = (count == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== sv/kwl_back.sv =====
`timescale 1ns / 1ps

module kwl_back #(
  parameter int KEYWORD_MAX_LEN = kwl_pkg::KWL_KEYWORD_MAX_LEN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  kwl_pkg::item_t   head_item,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output kwl_pkg::result_t res
);
  import kwl_pkg::*;

  localparam int WLW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int WIW = $clog2(KEYWORD_MAX_LEN);

  // Current character and rescan buffer.
  logic        busy;
  item_t       cur;
  logic        rescanning;
  logic [7:0]  rq [3];
  logic [1:0]  rcnt, ridx;

  // Scanner state.
  mode_t       mode, mode_next;
  logic [7:0]  word_chars [KEYWORD_MAX_LEN];
  logic [WLW-1:0] word_len, word_len_next;
  logic [7:0]  la0, la0_next, la1, la1_next;
  logic [1:0]  la_cnt, la_cnt_next;
  logic [7:0]  first_op, first_op_next;

  // Result hold and output registers.
  logic        hold_valid, hold_final;
  result_t     hold;
  logic        out_valid;
  result_t     out_res;

  // Step signals.
  logic [7:0]  ec;
  logic        eeoi;
  logic        emit;
  logic [1:0]  e_type;
  logic [8:0]  e_code;
  logic [7:0]  e_byte;
  logic        consumed;
  logic        w_app;
  logic [WLW-1:0] w_base;
  logic        rs_start;
  logic [1:0]  rs_cnt;
  logic [7:0]  rs_c2;
  logic        kw_short;
  logic [KW_CMP_LEN-1:0][7:0] kw_word;
  logic [8:0]  word_code;
  logic        out_free, hold_moves, step, fin;

  assign ec   = rescanning ? rq[ridx] : cur.ch;
  assign eeoi = !rescanning && cur.eoi;

  // Keyword check on the collected, upper-cased word.
  always_comb begin
    for (int k = 0; k < KW_CMP_LEN; k++) kw_word[k] = word_chars[k];
  end
  assign kw_short  = (word_len < WLW'(KW_CMP_LEN + 1));
  assign word_code = kw_short ? kw_code(kw_word, word_len[2:0], cur.cond) : TK_IDENT;

  // One scanner step on the effective character: at most one result.
  always_comb begin
    mode_next     = mode;
    emit          = 1'b0;
    e_type        = RT_TOKEN;
    e_code        = '0;
    e_byte        = '0;
    consumed      = 1'b1;
    w_app         = 1'b0;
    w_base        = word_len;
    la0_next      = la0;
    la1_next      = la1;
    la_cnt_next   = la_cnt;
    first_op_next = first_op;
    rs_start      = 1'b0;
    rs_cnt        = 2'd0;
    rs_c2         = ec;
    unique case (mode)
      M_IDLE: begin
        if (eeoi) begin
          emit   = 1'b1;
          e_type = RT_END;
        end else begin
          priority case (ec)
            " ", 8'h09, 8'h0A, 8'h0D: ;
            "/":  mode_next = M_SLASH;
            ";":  mode_next = M_COMMENT;
            "+", "-", "*", "^", "[", "]", "(", ")", "%", "&", "|", ",", "@", ".": begin
              emit   = 1'b1;
              e_code = {1'b0, ec};
            end
            "<", ">": begin
              first_op_next = ec;
              mode_next     = M_CMP;
            end
            "=":   mode_next = M_EQ1;
            8'h22: mode_next = M_STRING;
            "$":   mode_next = M_HEX;
            8'h27: mode_next = M_QUOTE;
            default: begin
              emit   = 1'b1;
              e_type = RT_BYTE;
              e_byte = ec;
              if (is_digit(ec)) begin
                mode_next = M_DEC;
              end else begin
                w_app     = 1'b1;
                w_base    = '0;
                mode_next = M_WORD;
              end
            end
          endcase
        end
      end
      M_SLASH: begin
        if (!eeoi && ec == "/") begin
          mode_next = M_COMMENT;
        end else begin
          emit      = 1'b1;
          e_code    = {1'b0, 8'h2F};
          mode_next = M_IDLE;
          consumed  = 1'b0;
        end
      end
      M_COMMENT: begin
        if (eeoi) begin
          emit      = 1'b1;
          e_type    = RT_ERROR;
          mode_next = M_IDLE;
        end else if (ec == 8'h0A) begin
          mode_next = M_IDLE;
        end
      end
      M_CMP: begin
        mode_next = M_IDLE;
        emit      = 1'b1;
        if (!eeoi && ec == "=") begin
          e_code = (first_op == ">") ? TK_GTE : TK_LTE;
        end else if (!eeoi && first_op == "<" && ec == ">") begin
          e_code = TK_NEQ;
        end else begin
          e_code   = {1'b0, first_op};
          consumed = 1'b0;
        end
      end
      M_EQ1: begin
        if (!eeoi && ec == "=") begin
          mode_next = M_EQ2;
        end else begin
          emit      = 1'b1;
          e_code    = {1'b0, 8'h3D};
          mode_next = M_IDLE;
          consumed  = 1'b0;
        end
      end
      M_EQ2: begin
        if (eeoi) begin
          emit      = 1'b1;
          e_code    = {1'b0, 8'h3D};
          mode_next = M_IDLE;
          consumed  = 1'b0;
        end else begin
          emit      = 1'b1;
          mode_next = M_IDLE;
          priority case (ec)
            "%": e_code = TK_ASSIGN_MOD;
            "&": e_code = TK_ASSIGN_AND;
            "*": e_code = TK_ASSIGN_MUL;
            "-": e_code = TK_ASSIGN_SUB;
            "+": e_code = TK_ASSIGN_ADD;
            "/": e_code = TK_ASSIGN_DIV;
            "|": e_code = TK_ASSIGN_OR;
            default: begin
              emit        = 1'b0;
              la0_next    = ec;
              la_cnt_next = 2'd1;
              mode_next   = M_COLLECT;
            end
          endcase
        end
      end
      M_COLLECT: begin
        if (!eeoi) begin
          if (la_cnt == 2'd0) begin
            la0_next    = ec;
            la_cnt_next = 2'd1;
          end else if (la_cnt == 2'd1) begin
            la1_next    = ec;
            la_cnt_next = 2'd2;
          end else begin
            // Third character decides between a shift or modulo assignment
            // and a failed guess that is scanned again.
            la_cnt_next = 2'd0;
            mode_next   = M_IDLE;
            emit        = 1'b1;
            if (upcase(la0) == "R" && upcase(la1) == "S" && upcase(ec) == "H") begin
              e_code = TK_RSHASSIGN;
            end else if (upcase(la0) == "L" && upcase(la1) == "S" && upcase(ec) == "H") begin
              e_code = TK_LSHASSIGN;
            end else if (upcase(la0) == "M" && upcase(la1) == "O" && upcase(ec) == "D") begin
              e_code = TK_MODASSIGN;
            end else begin
              e_code   = {1'b0, 8'h3D};
              rs_start = 1'b1;
              rs_cnt   = 2'd3;
              consumed = 1'b0;
            end
          end
        end else begin
          // End of input with a partial guess: emit the equals sign and scan
          // the held characters before the end marker.
          emit        = 1'b1;
          e_code      = {1'b0, 8'h3D};
          la_cnt_next = 2'd0;
          mode_next   = M_IDLE;
          consumed    = 1'b0;
          rs_start    = (la_cnt != 2'd0);
          rs_cnt      = la_cnt;
        end
      end
      M_STRING: begin
        emit = 1'b1;
        if (eeoi) begin
          e_type    = RT_ERROR;
          mode_next = M_IDLE;
        end else if (ec == 8'h22) begin
          e_code    = TK_STRING;
          mode_next = M_IDLE;
        end else begin
          e_type = RT_BYTE;
          e_byte = ec;
        end
      end
      M_DEC: begin
        emit = 1'b1;
        if (!eeoi && is_digit(ec)) begin
          e_type = RT_BYTE;
          e_byte = ec;
        end else begin
          e_code    = TK_CONSTANT;
          mode_next = M_IDLE;
          consumed  = 1'b0;
        end
      end
      M_HEX: begin
        emit = 1'b1;
        if (!eeoi && is_xdigit(ec)) begin
          e_type = RT_BYTE;
          e_byte = ec;
        end else begin
          e_code    = TK_HEX;
          mode_next = M_IDLE;
          consumed  = 1'b0;
        end
      end
      M_QUOTE: begin
        emit = 1'b1;
        if (eeoi) begin
          e_type    = RT_ERROR;
          mode_next = M_IDLE;
        end else begin
          e_type    = RT_BYTE;
          e_byte    = ec;
          mode_next = M_QEND;
          consumed  = 1'b0;
        end
      end
      M_QEND: begin
        emit      = 1'b1;
        e_code    = TK_CHARCONST;
        mode_next = M_IDLE;
      end
      M_WORD: begin
        emit = 1'b1;
        if (!eeoi && is_symbol(ec)) begin
          e_type = RT_BYTE;
          e_byte = ec;
          w_app  = 1'b1;
        end else begin
          e_code    = word_code;
          mode_next = M_IDLE;
          consumed  = 1'b0;
        end
      end
      default: begin
        mode_next = M_IDLE;
        consumed  = 1'b0;
      end
    endcase
  end

  // Word length grows to one past the keyword limit and then stops.
  always_comb begin
    word_len_next = word_len;
    if (w_app && w_base <= WLW'(KEYWORD_MAX_LEN)) word_len_next = w_base + 1'b1;
  end

  // Flow control: the hold register keeps the newest result until it is
  // known whether it is the last one of its character.
  assign out_free   = !out_valid || res_ready;
  assign hold_moves = hold_valid && out_free && (hold_final || (busy && emit));
  assign step       = busy && (!emit || !hold_valid || hold_moves);
  assign fin        = step && consumed &&
                      (rescanning ? (ridx == rcnt - 2'd1 && !cur.eoi) : 1'b1);
  assign pop        = head_valid && (!busy || fin);

  assign res_valid = out_valid;
  assign res       = out_res;

  // Word buffer holds only the first characters of a word.
  always_ff @(posedge clk) begin
    if (step && w_app && w_base < WLW'(KEYWORD_MAX_LEN)) begin
      word_chars[w_base[WIW-1:0]] <= upcase(ec);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) cur <= head_item;
    if (step && rs_start) begin
      rq[0] <= la0;
      rq[1] <= la1;
      rq[2] <= rs_c2;
      rcnt  <= rs_cnt;
    end
    if (step) begin
      la0      <= la0_next;
      la1      <= la1_next;
      first_op <= first_op_next;
    end
    if (step && emit) begin
      hold.rtype  <= e_type;
      hold.code   <= e_code;
      hold.lexeme <= e_byte;
      hold.line   <= cur.line;
      hold.column <= cur.column;
      hold.last   <= 1'b0;
    end
    // The last flag is the lowest bit of a result.
    if (hold_moves) out_res <= {hold[$bits(result_t)-1:1], hold_final};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      rescanning <= 1'b0;
      ridx       <= '0;
      mode       <= M_IDLE;
      word_len   <= '0;
      la_cnt     <= '0;
      hold_valid <= 1'b0;
      hold_final <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) busy <= 1'b1;
      else if (fin) busy <= 1'b0;

      if (step) begin
        mode     <= mode_next;
        word_len <= word_len_next;
        la_cnt   <= la_cnt_next;
        if (rs_start) begin
          rescanning <= 1'b1;
          ridx       <= '0;
        end else if (rescanning && consumed) begin
          if (ridx == rcnt - 2'd1) rescanning <= 1'b0;
          else ridx <= ridx + 1'b1;
        end
      end

      if (hold_moves) out_valid <= 1'b1;
      else if (res_ready) out_valid <= 1'b0;

      if (step && emit) begin
        hold_valid <= 1'b1;
        hold_final <= fin;
      end else begin
        if (hold_moves) hold_valid <= 1'b0;
        if (step && fin && hold_valid && !hold_final) hold_final <= 1'b1;
      end
    end
  end

endmodule

// ===== tb/keyword_lexer_top_tb.sv =====
`timescale 1ns / 1ps

module keyword_lexer_top_tb;
  import kwl_pkg::*;

  localparam int POS_MAX = 65535;
  localparam int MAX_RES = 8;

  // Character class codes used when building random source text.
  localparam int PICK_WORD    = 0;
  localparam int PICK_NUMBER  = 1;
  localparam int PICK_HEX     = 2;
  localparam int PICK_STRING  = 3;
  localparam int PICK_ASSIGN  = 4;
  localparam int PICK_CMP     = 5;
  localparam int PICK_COMMENT = 6;
  localparam int PICK_NOISE   = 7;

  // Idle phases.
  localparam int PH_NONE = 0;
  localparam int PH_SEND = 1;
  localparam int PH_RECV = 2;
  localparam int PH_BOTH = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  keyword_lexer_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Scanner state mirrored by the predictor.
  mode_t      scan_mode;
  logic [7:0] word_buf [KWL_KEYWORD_MAX_LEN];
  int         word_len;
  logic [7:0] held [3];
  int         held_cnt;
  logic [7:0] cmp_char;
  int         line_cnt;
  int         col_cnt;

  result_t    token_queue [$];
  result_t    step_out [$];
  int         fail_count = 0;
  int         idle_phase = PH_NONE;

  // Keyword names in code order for the predictor's own lookup.
  string kw_names [35] = '{
    "AND", "OR", "ARRAY", "POINTER", "BYTE", "CARD", "INT", "TYPE", "DO",
    "OD", "IF", "ELSEIF", "ELSE", "FI", "FOR", "TO", "STEP", "WHILE", "UNTIL",
    "EXIT", "PROC", "FUNC", "RETURN", "BEGIN", "END", "MODULE", "LSH", "RSH",
    "MOD", "THEN", "CHAR", "DEFINE", "XOR", "LONG", "INCLUDE"
  };

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_char(logic [7:0] c);
    return digit_char(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit name_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_char(c) || c == "_";
  endfunction

  task automatic push_result(logic [1:0] kind, logic [8:0] code, logic [7:0] b);
    result_t r;
    if (step_out.size() >= MAX_RES) return;
    r.rtype  = kind;
    r.code   = code;
    r.lexeme = b;
    r.line   = line_cnt[15:0];
    r.column = col_cnt[15:0];
    r.last   = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic word_add(logic [7:0] c);
    if (word_len < KWL_KEYWORD_MAX_LEN) word_buf[word_len] = to_upper(c);
    if (word_len <= KWL_KEYWORD_MAX_LEN) word_len++;
    push_result(RT_BYTE, 9'd0, c);
  endtask

  task automatic word_close(bit cond);
    logic [8:0] code;
    string s;
    code = TK_IDENT;
    if (word_len <= KWL_KEYWORD_MAX_LEN) begin
      s = "";
      for (int i = 0; i < word_len; i++) s = {s, string'(word_buf[i])};
      for (int i = 0; i < KW_COUNT; i++) begin
        // A zero byte vanishes from the text, so the length is compared too.
        if (word_len == kw_names[i].len() && s == kw_names[i]) begin
          code = (i == KW_RETURN_IDX && cond) ? TK_CRETURN : 9'(KW_BASE + i);
          break;
        end
      end
    end
    push_result(RT_TOKEN, code, 8'd0);
  endtask

  task automatic begin_token(logic [7:0] c);
    case (c)
      " ", "\t", "\n", 8'd13: ;
      "/": scan_mode = M_SLASH;
      ";": scan_mode = M_COMMENT;
      "+", "-", "*", "^", "[", "]", "(", ")", "%", "&", "|", ",", "@", ".":
        push_result(RT_TOKEN, {1'b0, c}, 8'd0);
      "<", ">": begin
        cmp_char  = c;
        scan_mode = M_CMP;
      end
      "=": scan_mode = M_EQ1;
      "\"": scan_mode = M_STRING;
      "$": scan_mode = M_HEX;
      "'": scan_mode = M_QUOTE;
      default: begin
        if (digit_char(c)) begin
          push_result(RT_BYTE, 9'd0, c);
          scan_mode = M_DEC;
        end else begin
          word_len = 0;
          word_add(c);
          scan_mode = M_WORD;
        end
      end
    endcase
  endtask

  // One pass of the scanner over a character; recursive for re-scanned bytes.
  task automatic scan_char(logic [7:0] c, bit eoi, bit cond);
    logic [7:0] q [3];
    logic [7:0] u [3];
    int n;
    bit done;
    done = 0;
    while (!done) begin
      case (scan_mode)
        M_IDLE: begin
          if (eoi) push_result(RT_END, 9'd0, 8'd0);
          else begin_token(c);
          done = 1;
        end
        M_SLASH: begin
          if (!eoi && c == "/") begin
            scan_mode = M_COMMENT;
            done = 1;
          end else begin
            push_result(RT_TOKEN, 9'd47, 8'd0);
            scan_mode = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (eoi) begin
            push_result(RT_ERROR, 9'd0, 8'd0);
            scan_mode = M_IDLE;
          end else if (c == "\n") scan_mode = M_IDLE;
          done = 1;
        end
        M_CMP: begin
          scan_mode = M_IDLE;
          if (!eoi && c == "=") begin
            push_result(RT_TOKEN, cmp_char == ">" ? TK_GTE : TK_LTE, 8'd0);
            done = 1;
          end else if (!eoi && cmp_char == "<" && c == ">") begin
            push_result(RT_TOKEN, TK_NEQ, 8'd0);
            done = 1;
          end else push_result(RT_TOKEN, {1'b0, cmp_char}, 8'd0);
        end
        M_EQ1: begin
          if (!eoi && c == "=") begin
            scan_mode = M_EQ2;
            done = 1;
          end else begin
            push_result(RT_TOKEN, 9'd61, 8'd0);
            scan_mode = M_IDLE;
          end
        end
        M_EQ2: begin
          if (eoi) begin
            push_result(RT_TOKEN, 9'd61, 8'd0);
            scan_mode = M_IDLE;
          end else begin
            done = 1;
            case (c)
              "%": push_result(RT_TOKEN, TK_ASSIGN_MOD, 8'd0);
              "&": push_result(RT_TOKEN, TK_ASSIGN_AND, 8'd0);
              "*": push_result(RT_TOKEN, TK_ASSIGN_MUL, 8'd0);
              "-": push_result(RT_TOKEN, TK_ASSIGN_SUB, 8'd0);
              "+": push_result(RT_TOKEN, TK_ASSIGN_ADD, 8'd0);
              "/": push_result(RT_TOKEN, TK_ASSIGN_DIV, 8'd0);
              "|": push_result(RT_TOKEN, TK_ASSIGN_OR, 8'd0);
              default: begin
                held[0]  = c;
                held_cnt = 1;
              end
            endcase
            scan_mode = (held_cnt == 1) ? M_COLLECT : M_IDLE;
          end
        end
        M_COLLECT: begin
          n = -1;
          if (!eoi) begin
            if (held_cnt < 3) held[held_cnt++] = c;
            if (held_cnt < 3) begin
              done = 1;
            end else begin
              for (int i = 0; i < 3; i++) u[i] = to_upper(held[i]);
              held_cnt  = 0;
              scan_mode = M_IDLE;
              done = 1;
              if ({u[0], u[1], u[2]} == "RSH") push_result(RT_TOKEN, TK_RSHASSIGN, 8'd0);
              else if ({u[0], u[1], u[2]} == "LSH")
                push_result(RT_TOKEN, TK_LSHASSIGN, 8'd0);
              else if ({u[0], u[1], u[2]} == "MOD")
                push_result(RT_TOKEN, TK_MODASSIGN, 8'd0);
              else n = 3;
            end
          end else begin
            n = held_cnt;
            held_cnt  = 0;
            scan_mode = M_IDLE;
          end
          if (n >= 0) begin
            q = held;
            push_result(RT_TOKEN, 9'd61, 8'd0);
            for (int i = 0; i < n; i++) scan_char(q[i], 1'b0, cond);
            if (!eoi) done = 1;
          end
        end
        M_STRING: begin
          if (eoi) begin
            push_result(RT_ERROR, 9'd0, 8'd0);
            scan_mode = M_IDLE;
          end else if (c == "\"") begin
            push_result(RT_TOKEN, TK_STRING, 8'd0);
            scan_mode = M_IDLE;
          end else push_result(RT_BYTE, 9'd0, c);
          done = 1;
        end
        M_DEC: begin
          if (!eoi && digit_char(c)) begin
            push_result(RT_BYTE, 9'd0, c);
            done = 1;
          end else begin
            push_result(RT_TOKEN, TK_CONSTANT, 8'd0);
            scan_mode = M_IDLE;
          end
        end
        M_HEX: begin
          if (!eoi && hex_char(c)) begin
            push_result(RT_BYTE, 9'd0, c);
            done = 1;
          end else begin
            push_result(RT_TOKEN, TK_HEX, 8'd0);
            scan_mode = M_IDLE;
          end
        end
        M_QUOTE: begin
          scan_mode = M_IDLE;
          if (eoi) push_result(RT_ERROR, 9'd0, 8'd0);
          else begin
            push_result(RT_BYTE, 9'd0, c);
            push_result(RT_TOKEN, TK_CHARCONST, 8'd0);
          end
          done = 1;
        end
        M_WORD: begin
          if (!eoi && name_char(c)) begin
            word_add(c);
            done = 1;
          end else begin
            word_close(cond);
            scan_mode = M_IDLE;
          end
        end
        default: scan_mode = M_IDLE;
      endcase
    end
  endtask

  // Works out the results of one input transfer and queues them.
  task automatic predict_tokens(logic [7:0] c, bit eoi, bit cond);
    step_out.delete();
    if (!eoi) begin
      if (c == "\n") begin
        if (line_cnt < POS_MAX) line_cnt++;
        col_cnt = 0;
      end else if (col_cnt < POS_MAX) col_cnt++;
    end
    scan_char(c, eoi, cond);
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) token_queue.push_back(step_out[i]);
  endtask

  // Sends one character, waiting for the handshake; valid stays high for a
  // following character unless the sender idles.
  task automatic send_char(logic [7:0] c, bit eoi, bit cond);
    while ((idle_phase == PH_SEND || idle_phase == PH_BOTH) && $urandom_range(99) < 81) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eoi;
    s_axis_tuser  <= cond;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_tokens(c, eoi, cond);
  endtask

  // Drops valid after the last character of a run.
  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(string s, bit cond);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0, cond);
  endtask

  // Receiver: random stalls and the comparison with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rtype  = m_axis_tuser;
        got.code   = m_axis_tdata[8:0];
        got.lexeme = m_axis_tdata[16:9];
        got.line   = m_axis_tdata[32:17];
        got.column = m_axis_tdata[48:33];
        got.last   = m_axis_tlast;
        if (token_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result %p", got);
        end else begin
          want = token_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
    m_axis_tready <= !((idle_phase == PH_RECV || idle_phase == PH_BOTH)
                       && $urandom_range(99) < 81);
  end

  typedef struct {
    logic [7:0] c;
    bit         eoi;
    bit         cond;
    bit         typed;
    logic [1:0] kind;
  } row_t;

  // Directed rows; rows with typed set carry an expected single result.
  row_t dir_rows [] = '{
    '{8'h00, 1, 0, 1, RT_END},
    '{"'", 0, 0, 0, RT_BYTE}, '{8'hFF, 0, 1, 0, RT_BYTE},
    '{"\"", 0, 0, 0, RT_BYTE}, '{8'h00, 1, 0, 1, RT_ERROR},
    '{";", 0, 0, 0, RT_BYTE}, '{8'h00, 1, 1, 1, RT_ERROR},
    '{"'", 0, 0, 0, RT_BYTE}, '{8'h00, 1, 0, 1, RT_ERROR},
    '{"=", 0, 0, 0, RT_BYTE}, '{"=", 0, 0, 0, RT_BYTE}, '{"x", 0, 0, 0, RT_BYTE},
    '{"y", 0, 0, 0, RT_BYTE}, '{8'h00, 1, 0, 0, RT_BYTE},
    '{"<", 0, 0, 0, RT_BYTE}, '{">", 0, 0, 0, RT_BYTE},
    '{">", 0, 0, 0, RT_BYTE}, '{"=", 0, 0, 0, RT_BYTE},
    '{"<", 0, 0, 0, RT_BYTE}, '{"=", 0, 0, 0, RT_BYTE},
    '{"/", 0, 0, 0, RT_BYTE}, '{"1", 0, 0, 0, RT_BYTE},
    '{8'h80, 0, 0, 0, RT_BYTE}, '{"\n", 0, 0, 0, RT_BYTE}
  };

  string snippets [] = '{
    "RETURN ", "return;x\n", "ELSEIF ", "include ", "pointer ", "==RSH ", "==lsh ",
    "==Mod ", "==% ", "==& ", "==* ", "==- ", "==+ ", "==/ ", "==| ", "==RSX ",
    "$fF09g ", "\"ab c\" ", "12345 ", "//note\n", "veryLongName_1 ", "'A ", "a_b9 "
  };

  function automatic logic [7:0] rand_from(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Random token with random content, where a string may be left unclosed, or a noise byte.
  task automatic send_random_token();
    int k;
    bit cond;
    cond = $urandom_range(1);
    case ($urandom_range(PICK_NOISE))
      PICK_WORD: begin
        if ($urandom_range(1)) send_text(kw_names[$urandom_range(KW_COUNT - 1)], cond);
        else begin
          k = $urandom_range(1, 10);
          for (int i = 0; i < k; i++)
            send_char(rand_from("abcXYZ_09rRsShH"), 1'b0, cond);
        end
      end
      PICK_NUMBER: begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) send_char(8'("0" + $urandom_range(9)), 1'b0, cond);
      end
      PICK_HEX: begin
        send_char("$", 1'b0, cond);
        k = $urandom_range(0, 4);
        for (int i = 0; i < k; i++) send_char(rand_from("0123456789abcdefABCDEF"), 1'b0, cond);
      end
      PICK_STRING: begin
        send_char("\"", 1'b0, cond);
        k = $urandom_range(0, 4);
        for (int i = 0; i < k; i++) send_char(8'($urandom_range(32, 126)), 1'b0, cond);
        if ($urandom_range(5) != 0) send_char("\"", 1'b0, cond);
      end
      PICK_ASSIGN: begin
        send_text("==", cond);
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) send_char(rand_from("%&*-+/|RSHLMODrsmx="), 1'b0, cond);
      end
      PICK_CMP: begin
        send_char(rand_from("<>"), 1'b0, cond);
        send_char(rand_from("=><a"), 1'b0, cond);
      end
      PICK_COMMENT: begin
        send_text($urandom_range(1) ? "//" : ";", cond);
        send_char(8'($urandom_range(255)), 1'b0, cond);
        send_char("\n", 1'b0, cond);
      end
      default: begin
        send_char(8'($urandom_range(255)), $urandom_range(15) == 0, cond);
      end
    endcase
    send_char(rand_from(" \n\t"), 1'b0, cond);
  endtask

  initial begin
    scan_mode = M_IDLE;
    word_len  = 0;
    held_cnt  = 0;
    cmp_char  = '0;
    line_cnt  = 1;
    col_cnt   = 0;
    foreach (word_buf[i]) word_buf[i] = '0;
    foreach (held[i]) held[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; for typed rows the predicted result is checked against the listed kind.
    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].c, dir_rows[i].eoi, dir_rows[i].cond);
      if (dir_rows[i].typed && (step_out.size() != 1
                                || step_out[0].rtype != dir_rows[i].kind)) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Row %0d: expected kind %0d, predicted %p", i, dir_rows[i].kind, step_out);
      end
    end
    foreach (snippets[i]) send_text(snippets[i], i % 2);
    send_char(8'h00, 1'b1, 1'b0);
    stop_sending();

    // The sender holds off until every expected result has arrived.
    while (token_queue.size() != 0) @(posedge clk);

    for (int ph = PH_NONE; ph <= PH_BOTH; ph++) begin
      idle_phase = ph;
      repeat (4) send_random_token();
    end
    idle_phase = PH_NONE;
    send_char(8'h00, 1'b1, 1'b0);
    stop_sending();

    while (token_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && token_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== keyword_lexer_top.f =====
sv/kwl_pkg.sv
sv/kwl_front.sv
sv/kwl_queue.sv
sv/kwl_back.sv
sv/keyword_lexer_top.sv
tb/keyword_lexer_top_tb.sv
